FILE: sv/mlfq_pkg.sv
// Shared types and constants for the feedback queue tick scheduler.
// Holds field widths, request and register codes and the controller interface.
// Depends on nothing.
package mlfq_pkg;

  localparam int ID_W = 22;
  localparam int USE_W = 4;
  localparam int REQ_W = 2;
  localparam int ELAPSED_W = 16;
  localparam int BOOST_W = 8;
  localparam int QUANTUM_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [USE_W-1:0] USAGE_MAX = 4'd15;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [BOOST_W-1:0] BOOST_RESET = 8'd10;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 4'd2;

  localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPDOWN_QUANTUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT = 2'd2;

  typedef struct packed {
    logic latch;
    logic exec;
    logic disp_sel;
    logic disp_slot;
    logic disp_id;
    logic g_sel;
    logic g_slot;
    logic g_id;
    logic r_init;
    logic r_i;
    logic r_iw;
    logic r_j;
    logic r_w;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic req_add;
    logic req_start;
    logic req_tick;
    logic cur_valid;
    logic due;
    logic any_queued;
    logic g_empty;
    logic j_last;
    logic i_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/mlfq_tick_scheduler.sv
// A tick with a boost reorders the queued entries by the rank count of the boost sort,
// which reads the work list once per compare.
// One item is in progress at a time; a finished result waits in the output register.
// Reset clears the queues, the running entry and elapsed time, and loads the
// registers with their defaults; the memories keep their contents.
module mlfq_tick_scheduler #(
  parameter int MAX_ENTRIES = 32,
  parameter int NUM_LEVELS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mlfq_pkg::REQ_W-1:0]          req_type,
  input  logic [mlfq_pkg::ID_W-1:0]           process_id,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mlfq_pkg::ID_W-1:0]           running_id,
  output logic                                running_valid,
  output logic [$clog2(NUM_LEVELS)-1:0]       running_level,
  output logic                                boosted,
  output logic                                finished,
  output logic                                add_rejected,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mlfq_pkg::cmd_t cmd;
  mlfq_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  mlfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlfq_dp #(.MAX_ENTRIES(MAX_ENTRIES), .NUM_LEVELS(NUM_LEVELS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req_type),
    .process_id    (process_id),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .running_id    (running_id),
    .running_valid (running_valid),
    .running_level (running_level),
    .boosted       (boosted),
    .finished      (finished),
    .add_rejected  (add_rejected)
  );

endmodule

FILE: sv/mlfq_ram.sv
// Generic single write port memory with a registered read port.
// Used for the entry table, the level queues and the boost work list.
// Depends on nothing.
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mlfq_ctrl.sv
// Sequencing state machine of the feedback queue tick scheduler.
// Drives the datapath through mlfq_pkg::cmd_t and follows mlfq_pkg::sts_t.
// Depends on mlfq_pkg.
module mlfq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mlfq_pkg::sts_t sts,
  output mlfq_pkg::cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_EXEC  = 14'b00000000000010,
    S_DSEL  = 14'b00000000000100,
    S_DSLOT = 14'b00000000001000,
    S_DID   = 14'b00000000010000,
    S_GSEL  = 14'b00000000100000,
    S_GSLOT = 14'b00000001000000,
    S_GID   = 14'b00000010000000,
    S_RINIT = 14'b00000100000000,
    S_RI    = 14'b00001000000000,
    S_RIW   = 14'b00010000000000,
    S_RJ    = 14'b00100000000000,
    S_RW    = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        priority if (sts.req_add) state_next = S_DONE;
        else if (sts.req_start) state_next = sts.cur_valid ? S_DONE : S_DSEL;
        else if (sts.req_tick) state_next = sts.due ? S_GSEL : S_DSEL;
        else state_next = S_DONE;
      end
      S_DSEL:  state_next = sts.any_queued ? S_DSLOT : S_DONE;
      S_DSLOT: state_next = S_DID;
      S_DID:   state_next = S_DONE;
      S_GSEL:  state_next = sts.any_queued ? S_GSLOT : S_RINIT;
      S_GSLOT: state_next = S_GID;
      S_GID:   state_next = S_GSEL;
      S_RINIT: state_next = sts.g_empty ? S_DSEL : S_RI;
      S_RI:    state_next = S_RIW;
      S_RIW:   state_next = S_RJ;
      S_RJ:    state_next = sts.j_last ? S_RW : S_RJ;
      S_RW:    state_next = sts.i_last ? S_DSEL : S_RI;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.latch     = (state == S_IDLE) && in_valid;
    cmd.exec      = (state == S_EXEC);
    cmd.disp_sel  = (state == S_DSEL);
    cmd.disp_slot = (state == S_DSLOT);
    cmd.disp_id   = (state == S_DID);
    cmd.g_sel     = (state == S_GSEL);
    cmd.g_slot    = (state == S_GSLOT);
    cmd.g_id      = (state == S_GID);
    cmd.r_init    = (state == S_RINIT);
    cmd.r_i       = (state == S_RI);
    cmd.r_iw      = (state == S_RIW);
    cmd.r_j       = (state == S_RJ);
    cmd.r_w       = (state == S_RW);
    cmd.done      = (state == S_DONE);
  end

`ifndef SYNTHESIS
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("A new item was taken while the previous one was in progress.");
`endif

endmodule

FILE: sv/mlfq_dp.sv
// Datapath of the feedback queue tick scheduler: queues, entry table, boost sort.
// Carries out the commands of mlfq_ctrl and holds the result register.
// Depends on mlfq_pkg and mlfq_ram.
module mlfq_dp #(
  parameter int MAX_ENTRIES = 32,
  parameter int NUM_LEVELS = 3
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [mlfq_pkg::REQ_W-1:0]            req_type,
  input  logic [mlfq_pkg::ID_W-1:0]             process_id,
  input  logic                                  cfg_valid,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  mlfq_pkg::cmd_t                        cmd,
  output mlfq_pkg::sts_t                        sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mlfq_pkg::ID_W-1:0]             running_id,
  output logic                                  running_valid,
  output logic [$clog2(NUM_LEVELS)-1:0]         running_level,
  output logic                                  boosted,
  output logic                                  finished,
  output logic                                  add_rejected
);

  localparam int SW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam int FA_W = $clog2(NUM_LEVELS * MAX_ENTRIES);
  localparam int IW = mlfq_pkg::ID_W;
  localparam int UW = mlfq_pkg::USE_W;
  localparam int EW = IW + LW + UW;
  localparam int GW = IW + SW;
  localparam logic [LW-1:0] TOP_LVL = LW'(NUM_LEVELS - 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  function automatic logic [FA_W-1:0] fifo_addr(input logic [LW-1:0] lvl,
                                                input logic [SW-1:0] pos);
    fifo_addr = FA_W'(lvl) * FA_W'(MAX_ENTRIES) + FA_W'(pos);
  endfunction

  logic [mlfq_pkg::REQ_W-1:0] req_q;
  logic [IW-1:0] pid_q;
  logic [mlfq_pkg::BOOST_W-1:0] boost_period, countdown;
  logic [mlfq_pkg::QUANTUM_W-1:0] quantum;
  logic [mlfq_pkg::ELAPSED_W-1:0] run_limit, elapsed;
  logic [SW-1:0] head [NUM_LEVELS];
  logic [CW-1:0] count [NUM_LEVELS];
  logic [CW-1:0] total;
  logic cur_valid;
  logic [SW-1:0] cur_slot;
  logic [IW-1:0] cur_id;
  logic [LW-1:0] cur_level;
  logic [UW-1:0] cur_use;
  logic [CW-1:0] g_n;
  logic [SW-1:0] g_slot;
  logic [SW-1:0] i_idx, j_idx, rank;
  logic [IW-1:0] elem_id;
  logic [SW-1:0] elem_slot;
  logic boost_f, fin_f, rej_f;

  logic [SW-1:0] fifo_rd;
  logic [EW-1:0] ent_rd;
  logic [GW-1:0] g_rd;
  logic fifo_we, ent_we;
  logic [FA_W-1:0] fifo_waddr;
  logic [SW-1:0] fifo_wdata, ent_waddr, g_raddr;
  logic [EW-1:0] ent_wdata;

  logic [LW-1:0] sel_lvl;
  logic any_q;
  logic [SW-1:0] head_inc;
  logic [UW-1:0] use_inc, rq_use;
  logic [LW-1:0] rq_lvl;
  logic due, drop;
  logic is_add, is_tick, do_add, do_requeue, push_en;
  logic [LW-1:0] push_lvl;
  logic [CW:0] pos_sum;
  logic [SW-1:0] push_pos;
  logic [mlfq_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic [IW-1:0] g_rd_id;
  logic [SW-1:0] g_rd_slot;
  logic less;

  always_comb begin
    sel_lvl = '0;
    any_q = 1'b0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (count[l] != '0) begin
        sel_lvl = LW'(l);
        any_q = 1'b1;
      end
    end
  end

  assign head_inc = (head[sel_lvl] == SW'(MAX_ENTRIES - 1)) ? '0 : head[sel_lvl] + SW'(1);

  assign use_inc = (cur_use != mlfq_pkg::USAGE_MAX) ? cur_use + UW'(1) : cur_use;
  assign due = (countdown <= mlfq_pkg::BOOST_W'(1));
  assign drop = !due && (use_inc >= quantum);
  assign rq_use = drop ? '0 : use_inc;
  assign rq_lvl = (drop && cur_level != '0) ? cur_level - LW'(1) : cur_level;
  assign elapsed_inc = elapsed + mlfq_pkg::ELAPSED_W'(1);

  assign is_add = (req_q == mlfq_pkg::REQ_ADD);
  assign is_tick = (req_q == mlfq_pkg::REQ_TICK);
  assign do_add = cmd.exec && is_add && (total != MAX_CNT);
  assign do_requeue = cmd.exec && is_tick && cur_valid;
  assign push_en = do_add || do_requeue;
  assign push_lvl = is_tick ? rq_lvl : TOP_LVL;
  assign pos_sum = (CW + 1)'(head[push_lvl]) + (CW + 1)'(count[push_lvl]);
  assign push_pos = (pos_sum >= (CW + 1)'(MAX_ENTRIES)) ?
                    SW'(pos_sum - (CW + 1)'(MAX_ENTRIES)) : SW'(pos_sum);

  assign fifo_we = push_en || cmd.r_w;
  assign fifo_waddr = cmd.r_w ? fifo_addr(TOP_LVL, rank) : fifo_addr(push_lvl, push_pos);
  assign fifo_wdata = cmd.r_w ? elem_slot : (is_tick ? cur_slot : SW'(total));

  assign ent_we = do_add || do_requeue || cmd.g_id;
  always_comb begin
    priority if (cmd.g_id) begin
      ent_waddr = g_slot;
      ent_wdata = {ent_rd[EW-1 -: IW], TOP_LVL, UW'(0)};
    end else if (is_tick) begin
      ent_waddr = cur_slot;
      ent_wdata = {cur_id, rq_lvl, rq_use};
    end else begin
      ent_waddr = SW'(total);
      ent_wdata = {pid_q, TOP_LVL, UW'(0)};
    end
  end

  always_comb begin
    priority if (cmd.r_iw) g_raddr = '0;
    else if (cmd.r_j) g_raddr = j_idx + SW'(1);
    else g_raddr = i_idx;
  end

  assign g_rd_id = g_rd[GW-1 -: IW];
  assign g_rd_slot = g_rd[SW-1:0];
  assign less = (g_rd_id < elem_id) || ((g_rd_id == elem_id) && (j_idx < i_idx));

  mlfq_ram #(.WIDTH(SW), .DEPTH(NUM_LEVELS * MAX_ENTRIES)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (fifo_addr(sel_lvl, head[sel_lvl])),
    .rdata (fifo_rd)
  );

  mlfq_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (fifo_rd),
    .rdata (ent_rd)
  );

  mlfq_ram #(.WIDTH(GW), .DEPTH(MAX_ENTRIES)) u_work_ram (
    .clk   (clk),
    .we    (cmd.g_id),
    .waddr (SW'(g_n)),
    .wdata ({ent_rd[EW-1 -: IW], g_slot}),
    .raddr (g_raddr),
    .rdata (g_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      boost_period <= mlfq_pkg::BOOST_RESET;
      countdown <= mlfq_pkg::BOOST_RESET;
      quantum <= mlfq_pkg::QUANTUM_RESET;
      run_limit <= '0;
      elapsed <= '0;
      total <= '0;
      cur_valid <= 1'b0;
      cur_slot <= '0;
      out_valid <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l] <= '0;
        count[l] <= '0;
      end
    end else begin
      if (cmd.exec) begin
        if (is_add) begin
          if (total != MAX_CNT) total <= total + CW'(1);
        end else if (is_tick) begin
          if (cur_valid) begin
            cur_valid <= 1'b0;
          end
          if (elapsed != mlfq_pkg::ELAPSED_MAX) elapsed <= elapsed_inc;
          countdown <= due ? boost_period : countdown - mlfq_pkg::BOOST_W'(1);
        end
      end
      if (push_en) begin
        count[push_lvl] <= count[push_lvl] + CW'(1);
      end
      if ((cmd.disp_sel || cmd.g_sel) && any_q) begin
        head[sel_lvl] <= head_inc;
        count[sel_lvl] <= count[sel_lvl] - CW'(1);
      end
      if (cmd.disp_sel && !any_q) cur_valid <= 1'b0;
      if (cmd.disp_slot) cur_slot <= fifo_rd;
      if (cmd.disp_id) cur_valid <= 1'b1;
      if (cmd.r_init) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          head[l] <= '0;
          count[l] <= '0;
        end
        count[TOP_LVL] <= g_n;
      end
      if (cmd.done && sts.out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          mlfq_pkg::CFG_BOOST_PERIOD: begin
            boost_period <= cfg_data[mlfq_pkg::BOOST_W-1:0];
            countdown <= cfg_data[mlfq_pkg::BOOST_W-1:0];
          end
          mlfq_pkg::CFG_STEPDOWN_QUANTUM: quantum <= cfg_data[mlfq_pkg::QUANTUM_W-1:0];
          mlfq_pkg::CFG_RUN_LIMIT: run_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req_type;
      pid_q <= process_id;
      boost_f <= 1'b0;
      fin_f <= 1'b0;
      rej_f <= 1'b0;
    end
    if (cmd.exec) begin
      if (is_add && total == MAX_CNT) rej_f <= 1'b1;
      if (is_tick) begin
        boost_f <= due;
        g_n <= '0;
        if (elapsed != mlfq_pkg::ELAPSED_MAX) begin
          fin_f <= (run_limit != '0) && (elapsed_inc == run_limit);
        end
      end
    end
    if (cmd.disp_id) begin
      cur_id <= ent_rd[EW-1 -: IW];
      cur_level <= ent_rd[UW +: LW];
      cur_use <= ent_rd[UW-1:0];
    end
    if (cmd.g_slot) g_slot <= fifo_rd;
    if (cmd.g_id) g_n <= g_n + CW'(1);
    if (cmd.r_init) i_idx <= '0;
    if (cmd.r_iw) begin
      elem_id <= g_rd_id;
      elem_slot <= g_rd_slot;
      j_idx <= '0;
      rank <= '0;
    end
    if (cmd.r_j) begin
      if (less) rank <= rank + SW'(1);
      j_idx <= j_idx + SW'(1);
    end
    if (cmd.r_w) i_idx <= i_idx + SW'(1);
    if (cmd.done && sts.out_free) begin
      running_id <= cur_valid ? cur_id : '0;
      running_valid <= cur_valid;
      running_level <= cur_valid ? cur_level : '0;
      boosted <= boost_f;
      finished <= fin_f;
      add_rejected <= rej_f;
    end
  end

  always_comb begin
    sts.req_add = is_add;
    sts.req_start = (req_q == mlfq_pkg::REQ_START);
    sts.req_tick = is_tick;
    sts.cur_valid = cur_valid;
    sts.due = due;
    sts.any_queued = any_q;
    sts.g_empty = (g_n == '0);
    sts.j_last = (CW'(j_idx) + CW'(1) == g_n);
    sts.i_last = (CW'(i_idx) + CW'(1) == g_n);
    sts.out_free = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= MAX_CNT)
    else $error("Entry count exceeds the table size.");
  a_total_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> total >= $past(total))
    else $error("Entry count went down.");
  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !running_valid |-> running_id == '0 && running_level == '0)
    else $error("A result with nothing running carries an ID or a level.");
`endif

endmodule

FILE: test/mlfq_tick_scheduler_tb.sv
// Self-checking testbench for the three-level feedback queue tick scheduler.
// It predicts every result from its own copy of the scheduler state and checks it.
// It depends on mlfq_pkg and mlfq_tick_scheduler.
`timescale 1ns / 1ps

module mlfq_tick_scheduler_tb;

  localparam int MAX_ENTRIES = 32;
  localparam int NUM_LEVELS = 3;
  localparam int TOP_LVL = NUM_LEVELS - 1;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [mlfq_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    logic                                is_cfg;
    logic [mlfq_pkg::REQ_W-1:0]          req;
    logic [mlfq_pkg::ID_W-1:0]           pid;
    logic [mlfq_pkg::CFG_IDX_W-1:0]      idx;
    logic [mlfq_pkg::CFG_DATA_W-1:0]     data;
  } pending_t;

  typedef struct packed {
    logic [mlfq_pkg::ID_W-1:0] id;
    logic                      rv;
    logic [1:0]                lvl;
    logic                      b;
    logic                      f;
    logic                      r;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [mlfq_pkg::REQ_W-1:0] req_type = '0;
  logic [mlfq_pkg::ID_W-1:0] process_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [mlfq_pkg::ID_W-1:0] running_id;
  logic running_valid;
  logic [1:0] running_level;
  logic boosted;
  logic finished;
  logic add_rejected;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mlfq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pending_t stim_q[$];
  sched_res_t sched_exp_q[$];

  logic [mlfq_pkg::ID_W-1:0] slot_id[MAX_ENTRIES];
  int slot_lvl[MAX_ENTRIES];
  int slot_use[MAX_ENTRIES];
  int lvl_q[NUM_LEVELS][$];
  int slot_total = 0;
  int run_slot = 0;
  bit run_on = 0;
  int elapsed = 0;
  int boost_left = 10;
  int boost_per = 10;
  int quantum = 2;
  int run_lim = 0;

  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_boosts = 0;
  int n_rejects = 0;
  int n_finish = 0;
  int n_cfg = 0;
  int in_gap = 0;
  int out_stall = 0;
  int quiet = 0;
  int idle_cycles = 0;

  mlfq_tick_scheduler #(.MAX_ENTRIES(MAX_ENTRIES), .NUM_LEVELS(NUM_LEVELS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void dispatch_next();
    for (int l = TOP_LVL; l >= 0; l--) begin
      if (lvl_q[l].size() > 0) begin
        run_slot = lvl_q[l].pop_front();
        run_on = 1;
        return;
      end
    end
    run_on = 0;
  endfunction

  function automatic void boost_all();
    int gathered[$];
    int s;
    int j;
    for (int l = TOP_LVL; l >= 0; l--) begin
      while (lvl_q[l].size() > 0) begin
        s = lvl_q[l].pop_front();
        slot_lvl[s] = TOP_LVL;
        slot_use[s] = 0;
        gathered.push_back(s);
      end
    end
    for (int i = 1; i < gathered.size(); i++) begin
      s = gathered[i];
      j = i;
      while (j > 0 && slot_id[gathered[j-1]] > slot_id[s]) begin
        gathered[j] = gathered[j-1];
        j--;
      end
      gathered[j] = s;
    end
    foreach (gathered[k]) lvl_q[TOP_LVL].push_back(gathered[k]);
  endfunction

  function automatic void apply_cfg(logic [mlfq_pkg::CFG_IDX_W-1:0] idx,
                                    logic [mlfq_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      mlfq_pkg::CFG_BOOST_PERIOD: begin
        boost_per = d[7:0];
        boost_left = boost_per;
      end
      mlfq_pkg::CFG_STEPDOWN_QUANTUM: quantum = d[3:0];
      mlfq_pkg::CFG_RUN_LIMIT: run_lim = d;
      default: ;
    endcase
  endfunction

  function automatic sched_res_t predict_sched(logic [mlfq_pkg::REQ_W-1:0] req,
                                               logic [mlfq_pkg::ID_W-1:0] pid);
    sched_res_t res;
    bit due;
    int s;
    res = '0;
    case (req)
      mlfq_pkg::REQ_ADD: begin
        if (slot_total >= MAX_ENTRIES) begin
          res.r = 1;
        end else begin
          slot_id[slot_total] = pid;
          slot_lvl[slot_total] = TOP_LVL;
          slot_use[slot_total] = 0;
          lvl_q[TOP_LVL].push_back(slot_total);
          slot_total++;
        end
      end
      mlfq_pkg::REQ_START: if (!run_on) dispatch_next();
      mlfq_pkg::REQ_TICK: begin
        if (run_on && slot_use[run_slot] < 15) slot_use[run_slot]++;
        if (elapsed < 65535) begin
          elapsed++;
          res.f = (run_lim != 0) && (elapsed == run_lim);
        end
        if (boost_left <= 1) begin
          due = 1;
          boost_left = boost_per;
        end else begin
          due = 0;
          boost_left--;
        end
        if (run_on) begin
          s = run_slot;
          if (!due && slot_use[s] >= quantum) begin
            slot_use[s] = 0;
            if (slot_lvl[s] > 0) slot_lvl[s]--;
          end
          lvl_q[slot_lvl[s]].push_back(s);
          run_on = 0;
        end
        if (due) begin
          boost_all();
          res.b = 1;
        end
        dispatch_next();
      end
      default: ;
    endcase
    if (run_on) begin
      res.id = slot_id[run_slot];
      res.rv = 1;
      res.lvl = slot_lvl[run_slot];
    end
    return res;
  endfunction

  task automatic push_item(logic [mlfq_pkg::REQ_W-1:0] req, logic [mlfq_pkg::ID_W-1:0] pid);
    stim_q.push_back('{1'b0, req, pid, '0, '0});
  endtask

  task automatic push_cfg(logic [mlfq_pkg::CFG_IDX_W-1:0] idx,
                          logic [mlfq_pkg::CFG_DATA_W-1:0] d);
    stim_q.push_back('{1'b1, '0, '0, idx, d});
  endtask

  task automatic push_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 14) push_item(mlfq_pkg::REQ_ADD, mlfq_pkg::ID_W'($urandom()));
      else if (r < 34) push_item(mlfq_pkg::REQ_START, mlfq_pkg::ID_W'($urandom()));
      else if (r < 95) push_item(mlfq_pkg::REQ_TICK, mlfq_pkg::ID_W'($urandom()));
      else push_item(REQ_UNKNOWN, mlfq_pkg::ID_W'($urandom()));
    end
  endtask

  always @(posedge clk) begin
    logic nv;
    logic ncv;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nv = in_valid;
      ncv = cfg_valid;
      if (in_valid && in_ready) begin
        sched_exp_q.push_back(predict_sched(req_type, process_id));
        void'(stim_q.pop_front());
        n_items++;
        nv = 1'b0;
        in_gap = gap_len();
      end
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
        void'(stim_q.pop_front());
        n_cfg++;
        ncv = 1'b0;
      end
      if (sched_exp_q.size() == 0 && !nv) quiet++;
      else quiet = 0;
      if (!nv && !ncv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (stim_q.size() > 0) begin
          if (stim_q[0].is_cfg) begin
            if (quiet >= 10) begin
              ncv = 1'b1;
              cfg_index <= stim_q[0].idx;
              cfg_data <= stim_q[0].data;
            end
          end else begin
            nv = 1'b1;
            req_type <= stim_q[0].req;
            process_id <= stim_q[0].pid;
          end
        end
      end
      in_valid <= nv;
      cfg_valid <= ncv;
    end
  end

  always @(posedge clk) begin
    sched_res_t got;
    sched_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{running_id, running_valid, running_level, boosted, finished, add_rejected};
        n_results++;
        if (sched_exp_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: id=%h v=%b lvl=%0d b=%b f=%b r=%b",
                   $time, got.id, got.rv, got.lvl, got.b, got.f, got.r);
        end else begin
          want = sched_exp_q.pop_front();
          n_boosts += want.b;
          n_finish += want.f;
          n_rejects += want.r;
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected id=%h v=%b lvl=%0d b=%b f=%b r=%b",
                     $time, want.id, want.rv, want.lvl, want.b, want.f, want.r);
            $display("%0t:          actual   id=%h v=%b lvl=%0d b=%b f=%b r=%b",
                     $time, got.id, got.rv, got.lvl, got.b, got.f, got.r);
          end
        end
        out_stall = (n_results == 150) ? 600 : gap_len();
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_ready <= (out_stall == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    push_cfg(mlfq_pkg::CFG_RUN_LIMIT, 16'd5);
    push_item(mlfq_pkg::REQ_TICK, '0);
    push_item(mlfq_pkg::REQ_START, '1);
    push_item(REQ_UNKNOWN, '1);
    push_item(mlfq_pkg::REQ_ADD, 22'h3FFFFF);
    push_item(mlfq_pkg::REQ_ADD, 22'h000000);
    push_item(mlfq_pkg::REQ_ADD, 22'h155555);
    push_item(mlfq_pkg::REQ_ADD, 22'h155555);
    push_item(mlfq_pkg::REQ_ADD, 22'h2AAAAA);
    push_item(mlfq_pkg::REQ_START, '0);
    push_item(mlfq_pkg::REQ_START, '0);
    for (int i = 0; i < 10; i++) push_item(mlfq_pkg::REQ_TICK, '0);
    push_item(REQ_UNKNOWN, '0);
    for (int i = 0; i < 28; i++) push_item(mlfq_pkg::REQ_ADD, mlfq_pkg::ID_W'($urandom()));
    push_item(mlfq_pkg::REQ_ADD, 22'h0ABCDE);
    push_item(mlfq_pkg::REQ_TICK, '1);

    push_cfg(mlfq_pkg::CFG_BOOST_PERIOD, 16'd1);
    push_cfg(mlfq_pkg::CFG_STEPDOWN_QUANTUM, 16'd1);
    push_cfg(mlfq_pkg::CFG_RUN_LIMIT, 16'hFFFF);
    push_random(90);
    push_cfg(mlfq_pkg::CFG_BOOST_PERIOD, 16'd255);
    push_cfg(mlfq_pkg::CFG_STEPDOWN_QUANTUM, 16'd15);
    push_cfg(mlfq_pkg::CFG_RUN_LIMIT, 16'd0);
    push_random(110);
    push_cfg(mlfq_pkg::CFG_BOOST_PERIOD, 16'd0);
    push_cfg(mlfq_pkg::CFG_STEPDOWN_QUANTUM, 16'd0);
    push_cfg(mlfq_pkg::CFG_RUN_LIMIT, 16'd1);
    push_random(60);
    for (int p = 0; p < 3; p++) begin
      push_cfg(mlfq_pkg::CFG_BOOST_PERIOD, 16'($urandom_range(2, 40)));
      push_cfg(mlfq_pkg::CFG_STEPDOWN_QUANTUM, 16'($urandom_range(1, 6)));
      push_cfg(mlfq_pkg::CFG_RUN_LIMIT, 16'($urandom_range(100, 300)));
      push_random(80);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (stim_q.size() > 0 || sched_exp_q.size() > 0 || in_valid) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d requests, %0d results, %0d register writes.",
             n_items, n_results, n_cfg);
    $display("Boosts %0d, rejected adds %0d, finished flags %0d, errors %0d.",
             n_boosts, n_rejects, n_finish, errors);
    if (errors == 0 && sched_exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mlfq_pkg.sv
sv/mlfq_ram.sv
sv/mlfq_ctrl.sv
sv/mlfq_dp.sv
sv/mlfq_tick_scheduler.sv
test/mlfq_tick_scheduler_tb.sv
